>>> hdl/smm_pkg.sv
package smm_pkg;

    localparam int ELEM_W  = 16;
    localparam int INDEX_W = 6;
    localparam int MUL_W   = 2 * ELEM_W;
    localparam int PROD_W  = 38;

    localparam logic [1:0] REQ_WRITE_A = 2'd0;
    localparam logic [1:0] REQ_WRITE_B = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic wr_a;      // store element into A
        logic wr_b;      // store element into B
        logic start;     // latch compute indices, clear accumulator
        logic issue;     // read one A/B element pair
        logic load_out;  // move accumulator to output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_range;   // request indices below DIM
        logic pipe_busy;  // reads or products still in flight
        logic out_free;   // output register can take a result
    } status_t;

endpackage

>>> hdl/smm_ram.sv
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/smm_ctrl.sv
module smm_ctrl #(
    parameter int DIM = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [1:0]         s_req_type,
    output logic               s_ready,
    input  smm_pkg::status_t   status,
    output smm_pkg::cmd_t      cmd
);

    import smm_pkg::*;

    localparam int IDX_W = $clog2(DIM);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic               accept;
    logic               last_k;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign last_k  = (k_reg == IDX_W'(DIM - 1));

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        cmd          = '0;
        cmd.wr_a     = accept && (s_req_type == REQ_WRITE_A) && status.in_range;
        cmd.wr_b     = accept && (s_req_type == REQ_WRITE_B) && status.in_range;
        unique case (state_reg)
            ST_IDLE: begin
                k_next = '0;
                if (accept && (s_req_type == REQ_COMPUTE)) begin
                    cmd.start  = 1'b1;
                    state_next = status.in_range ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                k_next    = k_reg + IDX_W'(1);
                if (last_k) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // out-of-range compute skips the MAC loop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_req_type == REQ_COMPUTE) && !status.in_range)
        |=> (state_reg == ST_FINISH))
        else $error("out-of-range compute did not go to finish");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over a waiting result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DRAIN) && status.pipe_busy) |=> (state_reg == ST_DRAIN))
        else $error("drain left with products in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && last_k) |=> !cmd.issue)
        else $error("more than DIM element pairs issued");

endmodule

>>> hdl/smm_datapath.sv
module smm_datapath #(
    parameter int DIM = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic        [smm_pkg::INDEX_W-1:0]     s_row_index,
    input  logic        [smm_pkg::INDEX_W-1:0]     s_col_index,
    input  logic signed [smm_pkg::ELEM_W-1:0]      s_elem_value,
    input  smm_pkg::cmd_t                          cmd,
    output smm_pkg::status_t                       status,
    output logic signed [smm_pkg::PROD_W-1:0]      m_product_value,
    output logic        [smm_pkg::INDEX_W-1:0]     m_out_row,
    output logic        [smm_pkg::INDEX_W-1:0]     m_out_col,
    output logic                                   m_valid,
    input  logic                                   m_ready
);

    import smm_pkg::*;

    localparam int DEPTH  = DIM * DIM;
    localparam int IDX_W  = $clog2(DIM);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [ADDR_W-1:0]        row_base;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0]        b_addr_reg, b_addr_next;
    logic [INDEX_W-1:0]       row_reg, col_reg;
    logic [ELEM_W-1:0]        a_rdata, b_rdata;
    logic                     rd_valid_reg, mul_valid_reg;
    logic signed [MUL_W-1:0]  product_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic                     m_valid_reg;
    logic signed [PROD_W-1:0] m_product_value_reg;
    logic [INDEX_W-1:0]       m_out_row_reg, m_out_col_reg;

    assign status.in_range = ({1'b0, s_row_index} < (INDEX_W + 1)'(DIM)) &&
                             ({1'b0, s_col_index} < (INDEX_W + 1)'(DIM));
    assign status.pipe_busy = rd_valid_reg || mul_valid_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

    // row-major address; only used when indices are in range
    assign row_base = ADDR_W'(s_row_index[IDX_W-1:0]) * ADDR_W'(DIM);
    assign wr_addr  = row_base + ADDR_W'(s_col_index[IDX_W-1:0]);

    // A walks along its row, B down its column
    always_comb begin
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        if (cmd.start) begin
            a_addr_next = row_base;
            b_addr_next = ADDR_W'(s_col_index[IDX_W-1:0]);
        end else if (cmd.issue) begin
            a_addr_next = a_addr_reg + ADDR_W'(1);
            b_addr_next = b_addr_reg + ADDR_W'(DIM);
        end
    end

    smm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (cmd.wr_a),
        .wr_addr (wr_addr),
        .wr_data (s_elem_value),
        .rd_en   (cmd.issue),
        .rd_addr (a_addr_reg),
        .rd_data (a_rdata)
    );

    smm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (cmd.wr_b),
        .wr_addr (wr_addr),
        .wr_data (s_elem_value),
        .rd_en   (cmd.issue),
        .rd_addr (b_addr_reg),
        .rd_data (b_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rd_valid_reg  <= cmd.issue;
            mul_valid_reg <= rd_valid_reg;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_addr_reg  <= a_addr_next;
        b_addr_reg  <= b_addr_next;
        product_reg <= MUL_W'($signed(a_rdata)) * MUL_W'($signed(b_rdata));
        if (cmd.start) begin
            row_reg <= s_row_index;
            col_reg <= s_col_index;
            acc_reg <= '0;
        end else if (mul_valid_reg) begin
            acc_reg <= acc_reg + PROD_W'(product_reg);
        end
        if (cmd.load_out) begin
            m_product_value_reg <= acc_reg;
            m_out_row_reg       <= row_reg;
            m_out_col_reg       <= col_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_product_value = m_product_value_reg;
    assign m_out_row       = m_out_row_reg;
    assign m_out_col       = m_out_col_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!rd_valid_reg && !mul_valid_reg))
        else $error("result loaded before accumulation finished");

endmodule

>>> hdl/square_matrix_multiply_top.sv
// Square integer matrix multiply, DIM x DIM, signed 16-bit elements.
//
// Input channel (s_valid / s_ready): each request carries s_req_type,
// s_row_index, s_col_index and s_elem_value. A write-A or write-B request
// stores s_elem_value at [row][col] of that matrix; a write
// with an index >= DIM is dropped. Request code 3 is dropped silently.
// A compute request returns one result on the output channel
// (m_valid / m_ready): the exact 38-bit dot product of row s_row_index of A
// with column s_col_index of B, plus the echoed indices. Out-of-range
// indices give a zero product.
//
// Timing: writes are taken back to back, one per cycle, while the block
// is idle. A compute runs DIM element pairs, one per cycle, through one
// multiply-accumulate unit fed by two registered-read RAMs; the result
// moves to the output register once the products have drained and that
// register is free, then requests are taken again. An out-of-range
// compute skips the loop. The output register holds a result until m_ready;
// meanwhile new requests, including a compute, are still taken, and a second
// result waits in the accumulator until the output register frees up.
// Reset (aresetn, synchronous, active low) clears control state only;
// matrix contents are undefined until written.
module square_matrix_multiply_top #(
    parameter int DIM = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic        [1:0]                  s_req_type,
    input  logic        [smm_pkg::INDEX_W-1:0] s_row_index,
    input  logic        [smm_pkg::INDEX_W-1:0] s_col_index,
    input  logic signed [smm_pkg::ELEM_W-1:0]  s_elem_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [smm_pkg::PROD_W-1:0]  m_product_value,
    output logic        [smm_pkg::INDEX_W-1:0] m_out_row,
    output logic        [smm_pkg::INDEX_W-1:0] m_out_col
);

    import smm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: request decode, MAC loop count, result hand-off
    smm_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // matrix RAMs, address walkers, multiplier, accumulator, output register
    smm_datapath #(
        .DIM (DIM)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_elem_value    (s_elem_value),
        .cmd             (cmd),
        .status          (status),
        .m_product_value (m_product_value),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_valid         (m_valid),
        .m_ready         (m_ready)
    );

endmodule

>>> dv/tb_square_matrix_multiply_top.sv
`timescale 1ns / 1ps

module tb_square_matrix_multiply_top;

    import smm_pkg::*;

    localparam int DIM            = 16;
    localparam int RAND_ITEMS     = 200;
    localparam int CALM_ITEMS     = 60;    // tail of the run with no idling or stalls
    localparam int WATCHDOG_LIMIT = 1000;  // quiet cycles before the watchdog fires
    // A rows and B columns 0 .. FILL_LINES-1, plus the last one, are loaded
    localparam int FILL_LINES     = 6;

    // the fourth request code, unused by the block
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Fill pattern for rows 0/1 of A and columns 0..2 of B: full-scale
    // products whose sums can be typed in directly.
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
    localparam logic signed [PROD_W-1:0] SUM_MIN_MIN = 38'sd17179869184;   //  16 * 2^30
    localparam logic signed [PROD_W-1:0] SUM_MAX_MIN = -38'sd17179344896;  // -16 * 32767 * 32768
    localparam logic signed [PROD_W-1:0] SUM_MAX_MAX = 38'sd17178820624;   //  16 * 32767^2

    // One expected result, held until the block returns it.
    typedef struct packed {
        logic signed [PROD_W-1:0]  product;
        logic        [INDEX_W-1:0] row;
        logic        [INDEX_W-1:0] col;
    } product_entry_t;

    // One row of the directed table. pinned marks a row whose result is
    // typed in; all other compute rows go through the predictor.
    typedef struct packed {
        logic        [1:0]         kind;
        logic        [INDEX_W-1:0] row;
        logic        [INDEX_W-1:0] col;
        logic signed [ELEM_W-1:0]  val;
        logic                      pinned;
        logic signed [PROD_W-1:0]  prod;
    } stim_row_t;

    logic                      aclk         = 1'b0;
    logic                      aresetn      = 1'b0;
    logic                      s_valid      = 1'b0;
    logic                      s_ready;
    logic        [1:0]         s_req_type   = REQ_WRITE_A;
    logic        [INDEX_W-1:0] s_row_index  = '0;
    logic        [INDEX_W-1:0] s_col_index  = '0;
    logic signed [ELEM_W-1:0]  s_elem_value = '0;
    logic                      m_valid;
    logic                      m_ready      = 1'b0;
    logic signed [PROD_W-1:0]  m_product_value;
    logic        [INDEX_W-1:0] m_out_row;
    logic        [INDEX_W-1:0] m_out_col;

    // Typed-in expectation riding along with the current request.
    logic                      hold_pinned  = 1'b0;
    logic signed [PROD_W-1:0]  hold_product = '0;

    // Shadow copies of both matrices, updated on every accepted in-range write.
    logic signed [ELEM_W-1:0]  shadow_a [DIM*DIM];
    logic signed [ELEM_W-1:0]  shadow_b [DIM*DIM];
    product_entry_t            pending_products [$];

    bit idle_on  = 1'b0;  // sender inserts gaps
    bit stall_on = 1'b0;  // receiver drops m_ready
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;
    int requests_seen = 0;
    int computes_seen = 0;
    int results_seen  = 0;

    square_matrix_multiply_top #(
        .DIM(DIM)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_row_index    (s_row_index),
        .s_col_index    (s_col_index),
        .s_elem_value   (s_elem_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_product_value(m_product_value),
        .m_out_row      (m_out_row),
        .m_out_col      (m_out_col)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor: exact dot product of row r of A with column c of B.
    // Out-of-range indices give zero. Truncated to the port width.
    // ---------------------------------------------------------------
    function automatic logic signed [PROD_W-1:0] dot_row_col(input int r, input int c);
        longint acc;
        int     k;
        acc = 0;
        if (r < DIM && c < DIM) begin
            for (k = 0; k < DIM; k++) begin
                acc += longint'(shadow_a[r*DIM + k]) * longint'(shadow_b[k*DIM + c]);
            end
        end
        return acc[PROD_W-1:0];
    endfunction

    // Random element, with the extremes showing up often.
    function automatic logic signed [ELEM_W-1:0] rand_elem();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return ELEM_MIN;
        if (pick == 1) return ELEM_MAX;
        return ELEM_W'($urandom_range(0, 65535));
    endfunction

    // Random index of a loaded A row or B column.
    function automatic logic [INDEX_W-1:0] rand_loaded();
        int pick;
        pick = $urandom_range(0, FILL_LINES);
        if (pick == FILL_LINES) return INDEX_W'(DIM - 1);
        return INDEX_W'(pick);
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Request driver. Payload changes at the falling edge; the request
    // counts as taken at the first rising edge with s_ready high.
    // Valid stays up across back-to-back requests unless a gap is drawn.
    // ---------------------------------------------------------------
    task automatic send_request(
        input logic        [1:0]         kind,
        input logic        [INDEX_W-1:0] row,
        input logic        [INDEX_W-1:0] col,
        input logic signed [ELEM_W-1:0]  val,
        input logic                      pinned,
        input logic signed [PROD_W-1:0]  prod
    );
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge aclk);
        end
        s_req_type   = kind;
        s_row_index  = row;
        s_col_index  = col;
        s_elem_value = val;
        hold_pinned  = pinned;
        hold_product = prod;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver back-pressure: random bursts with m_ready low.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready = 1'b0;
        end else if (stall_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: each taken request updates the shadow matrices or queues
    // an expected result; each taken result is checked against the
    // oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        product_entry_t got_entry;
        product_entry_t want_entry;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                got_entry.product = m_product_value;
                got_entry.row     = m_out_row;
                got_entry.col     = m_out_col;
                if (pending_products.size() == 0) begin
                    report_mismatch("product_value of a result with no request waiting",
                                    got_entry.product, 0);
                end else begin
                    want_entry = pending_products.pop_front();
                    if (got_entry.product !== want_entry.product)
                        report_mismatch("product_value", got_entry.product, want_entry.product);
                    if (got_entry.row !== want_entry.row)
                        report_mismatch("out_row", got_entry.row, want_entry.row);
                    if (got_entry.col !== want_entry.col)
                        report_mismatch("out_col", got_entry.col, want_entry.col);
                end
            end
            if (s_valid && s_ready) begin
                requests_seen++;
                case (s_req_type)
                    REQ_WRITE_A: begin
                        if (s_row_index < DIM && s_col_index < DIM)
                            shadow_a[s_row_index*DIM + s_col_index] = s_elem_value;
                    end
                    REQ_WRITE_B: begin
                        if (s_row_index < DIM && s_col_index < DIM)
                            shadow_b[s_row_index*DIM + s_col_index] = s_elem_value;
                    end
                    REQ_COMPUTE: begin
                        computes_seen++;
                        want_entry.product = hold_pinned ? hold_product
                                                         : dot_row_col(s_row_index, s_col_index);
                        want_entry.row = s_row_index;
                        want_entry.col = s_col_index;
                        pending_products.push_back(want_entry);
                    end
                    default: ;  // unused code: no result, no state change
                endcase
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck
    // or a result went missing.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d results outstanding",
                     $realtime, WATCHDOG_LIMIT, pending_products.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : main
        stim_row_t                 dir_tbl [$];
        stim_row_t                 cur;
        int                        i;
        int                        n;
        int                        pick;
        int                        fill_line;
        logic        [1:0]         kind;
        logic        [INDEX_W-1:0] row;
        logic        [INDEX_W-1:0] col;
        logic signed [ELEM_W-1:0]  val;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Load every A row and B column that a compute reads: no compute
        // may read an element that was never written.
        idle_on  = 1'b1;
        stall_on = 1'b1;
        for (i = 0; i < (FILL_LINES + 1)*DIM; i++) begin
            fill_line = (i / DIM < FILL_LINES) ? i / DIM : DIM - 1;
            if (fill_line == 0)      val = ELEM_MIN;
            else if (fill_line == 1) val = ELEM_MAX;
            else                     val = rand_elem();
            send_request(REQ_WRITE_A, INDEX_W'(fill_line), INDEX_W'(i % DIM), val, 1'b0, '0);
        end
        for (i = 0; i < (FILL_LINES + 1)*DIM; i++) begin
            fill_line = (i / DIM < FILL_LINES) ? i / DIM : DIM - 1;
            if (fill_line < 2)       val = ELEM_MIN;
            else if (fill_line == 2) val = ELEM_MAX;
            else                     val = rand_elem();
            send_request(REQ_WRITE_B, INDEX_W'(i % DIM), INDEX_W'(fill_line), val, 1'b0, '0);
        end

        // Directed part: full-scale sums, out-of-range computes and writes,
        // the unused code, then a few corner writes checked by prediction.
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd0,  6'd0,  16'sd0,  1'b1, SUM_MIN_MIN});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd1,  6'd1,  16'sd0,  1'b1, SUM_MAX_MIN});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd1,  6'd2,  16'sd0,  1'b1, SUM_MAX_MAX});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd0,  6'd2,  16'sd0,  1'b1, SUM_MAX_MIN});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd16, 6'd0,  16'sd0,  1'b1, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd0,  6'd16, 16'sd0,  1'b1, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd63, 6'd63, -16'sd1, 1'b1, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_UNUSED,  6'd3,  6'd3,  ELEM_MAX, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_UNUSED,  6'd63, 6'd0,  ELEM_MIN, 1'b0, 38'sd0});
        // dropped writes; a wrapped address would land in row 1 / column 1
        dir_tbl.push_back(stim_row_t'{REQ_WRITE_A, 6'd0,  6'd20, 16'sd1234, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_WRITE_B, 6'd20, 6'd1,  -16'sd1, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_WRITE_A, 6'd63, 6'd63, ELEM_MAX, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_WRITE_B, 6'd1,  6'd63, ELEM_MAX, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd1,  6'd1,  16'sd0,  1'b1, SUM_MAX_MIN});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd0,  6'd0,  16'sd0,  1'b1, SUM_MIN_MIN});
        // last row / last column corners
        dir_tbl.push_back(stim_row_t'{REQ_WRITE_A, 6'd15, 6'd15, ELEM_MAX, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_WRITE_B, 6'd15, 6'd15, ELEM_MIN, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd15, 6'd15, 16'sd0,  1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_WRITE_A, 6'd15, 6'd0,  16'sd0,  1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_WRITE_B, 6'd0,  6'd15, -16'sd1, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd15, 6'd15, 16'sh5555, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd15, 6'd0,  16'shAAAA, 1'b0, 38'sd0});
        dir_tbl.push_back(stim_row_t'{REQ_COMPUTE, 6'd0,  6'd15, 16'sd0,  1'b0, 38'sd0});

        foreach (dir_tbl[j]) begin
            cur = dir_tbl[j];
            send_request(cur.kind, cur.row, cur.col, cur.val, cur.pinned, cur.prod);
        end

        // Random part: mostly in-range writes and computes, a little noise.
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 40 == 0) begin
                idle_on  = ($urandom_range(0, 2) != 0);
                stall_on = ($urandom_range(0, 2) != 0);
            end
            if (n >= RAND_ITEMS - CALM_ITEMS) begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            pick = $urandom_range(0, 99);
            row  = INDEX_W'($urandom_range(0, DIM - 1));
            col  = INDEX_W'($urandom_range(0, DIM - 1));
            val  = rand_elem();
            if (pick < 38) begin
                kind = REQ_WRITE_A;
                row  = rand_loaded();
            end else if (pick < 70) begin
                kind = REQ_WRITE_B;
                col  = rand_loaded();
            end else if (pick < 92) begin
                kind = REQ_COMPUTE;
                row  = rand_loaded();
                col  = rand_loaded();
            end else if (pick < 97) begin
                // out of range on one index or both
                kind = (pick < 95) ? REQ_COMPUTE : (pick[0] ? REQ_WRITE_A : REQ_WRITE_B);
                case ($urandom_range(0, 2))
                    0:       row = INDEX_W'($urandom_range(DIM, 63));
                    1:       col = INDEX_W'($urandom_range(DIM, 63));
                    default: begin
                        row = INDEX_W'($urandom_range(DIM, 63));
                        col = INDEX_W'($urandom_range(DIM, 63));
                    end
                endcase
            end else begin
                kind = REQ_UNUSED;
                row  = INDEX_W'($urandom_range(0, 63));
                col  = INDEX_W'($urandom_range(0, 63));
            end
            send_request(kind, row, col, val, 1'b0, '0);
        end

        // Drain, then settle long enough to catch a stray extra result.
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_products.size() != 0) @(posedge aclk);
        repeat (DIM + 10) @(posedge aclk);

        $display("Run covered %0d requests, %0d of them computes; %0d results compared.",
                 requests_seen, computes_seen, results_seen);
        $display("Loaded rows and columns, full-scale and out-of-range cases, %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/smm_pkg.sv
hdl/smm_ram.sv
hdl/smm_ctrl.sv
hdl/smm_datapath.sv
hdl/square_matrix_multiply_top.sv
dv/tb_square_matrix_multiply_top.sv
